FILE: design/dehp_pkg.sv
// Shared types, codes and constants for the DICOM element header parser.
`timescale 1ns / 1ps
package dehp_pkg;

  localparam int PreambleBytesDefault = 128;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_VALUE   = 3'd1,
    KIND_END_OK  = 3'd2,
    KIND_NO_DICM = 3'd3,
    KIND_SYNTAX  = 3'd4,
    KIND_TRUNC   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_PRE, PH_MAGIC, PH_TAG, PH_VR, PH_RES, PH_LEN16, PH_LEN32, PH_VALUE
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] group_id;
    logic [15:0] element_id;
    logic [15:0] vr_code;
    logic [31:0] value_length;
    logic [7:0]  value_byte;
    logic        last_of_element;
    logic        little_endian;
    logic        explicit_vr;
  } rec_t;

  // write side of the record queue
  typedef struct packed {
    logic [1:0] count;
    rec_t       r0;
    rec_t       r1;
  } qwr_t;

  localparam logic [15:0] GRP_META = 16'h0002;
  localparam logic [15:0] GRP_ITEM = 16'hFFFE;
  localparam logic [15:0] EL_ITEM = 16'hE000;
  localparam logic [15:0] EL_ITEM_END = 16'hE00D;
  localparam logic [15:0] EL_SEQ_END = 16'hE0DD;
  localparam logic [15:0] EL_SYNTAX = 16'h0010;
  localparam logic [31:0] LEN_UNDEF = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC = "DICM";

  localparam logic [159:0] UID_LE_EXPL = {"1.2.840.10008.1.2.1", 8'h00};
  localparam logic [159:0] UID_BE_EXPL = {"1.2.840.10008.1.2.2", 8'h00};
  localparam logic [159:0] UID_LE_IMPL = {"1.2.840.10008.1.2", 24'h0};

  function automatic logic [7:0] uid_char(input logic [1:0] k, input logic [4:0] i);
    logic [4:0] j;
    j = 5'd19 - i;
    case (k)
      2'd0:    uid_char = UID_LE_EXPL[{j, 3'b000} +: 8];
      2'd1:    uid_char = UID_BE_EXPL[{j, 3'b000} +: 8];
      default: uid_char = UID_LE_IMPL[{j, 3'b000} +: 8];
    endcase
  endfunction

  function automatic logic long_vr(input logic [15:0] v);
    long_vr = (v == "OB") || (v == "OW") || (v == "OF") ||
              (v == "UT") || (v == "SQ") || (v == "UN");
  endfunction

  function automatic rec_t mk(input kind_t k, input logic [15:0] g, input logic [15:0] e,
                              input logic [15:0] v, input logic [31:0] l,
                              input logic [7:0] b, input logic la,
                              input logic le, input logic ex);
    rec_t r;
    r.kind = k;
    r.group_id = g;
    r.element_id = e;
    r.vr_code = v;
    r.value_length = l;
    r.value_byte = b;
    r.last_of_element = la;
    r.little_endian = le;
    r.explicit_vr = ex;
    mk = r;
  endfunction

endpackage

FILE: design/dehp_parser.sv
// Front end: per-byte element parser producing up to two records per byte.
`timescale 1ns / 1ps
module dehp_parser
  import dehp_pkg::*;
#(
  parameter int PREAMBLE_BYTES = PreambleBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        take,
  input  logic [7:0]  data_byte,
  output qwr_t        qwr
);

  localparam logic [31:0] PreLen = 32'(PREAMBLE_BYTES);

  phase_t      phase, phase_next;
  logic [31:0] slen, pos, pos_next;
  logic [2:0]  fbc, fbc_next;
  logic [15:0] tg, tg_next, te, te_next, vr, vr_next;
  logic [31:0] len, len_next, rem, rem_next;
  logic        ex, ex_next, le, le_next, halted, halted_next;
  logic [2:0]  uidm, uidm_next;

  always_comb begin
    rec_t        e;
    logic [1:0]  n;
    logic        do_fin, do_done, do_next, last;
    logic [31:0] idx;
    logic        m0, m1, m2;
    phase_next = phase; pos_next = pos; fbc_next = fbc; tg_next = tg; te_next = te;
    vr_next = vr; len_next = len; rem_next = rem; ex_next = ex; le_next = le;
    halted_next = halted; uidm_next = uidm;
    n = 2'd0; do_fin = 1'b0; do_done = 1'b0; do_next = 1'b0; last = 1'b0;
    idx = len - rem;
    m0 = 1'b0; m1 = 1'b0; m2 = 1'b0;
    e = '0;
    qwr.r0 = '0; qwr.r1 = '0;
    if (take && !halted) begin
      if (pos >= slen) begin
        e = mk(KIND_TRUNC, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 1'b0, le, ex);
        qwr.r0 = e; n = 2'd1; halted_next = 1'b1;
      end else begin
        pos_next = pos + 32'd1;
        if (phase == PH_PRE && pos >= PreLen) begin
          phase_next = PH_MAGIC; fbc_next = 3'd0;
        end
        unique case (phase_next)
          PH_PRE: ;
          PH_MAGIC: begin
            if (data_byte != MAGIC[{2'd3 - fbc_next[1:0], 3'b000} +: 8]) begin
              e = mk(KIND_NO_DICM, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 1'b0, le, ex);
              qwr.r0 = e; n = 2'd1; halted_next = 1'b1;
            end else begin
              fbc_next = fbc_next + 3'd1;
              if (fbc_next >= 3'd4) do_next = 1'b1;
            end
          end
          PH_TAG: begin
            case (fbc[1:0])
              2'd0: tg_next = {8'h0, data_byte};
              2'd1: tg_next = {data_byte, tg[7:0]};
              2'd2: te_next = {8'h0, data_byte};
              default: te_next = {data_byte, te[7:0]};
            endcase
            fbc_next = fbc + 3'd1;
            if (fbc_next >= 3'd4) begin
              fbc_next = 3'd0; vr_next = 16'h0; len_next = 32'h0;
              if (tg_next == GRP_META) phase_next = PH_VR;
              else if (tg_next == GRP_ITEM) begin
                if (te_next == EL_ITEM || te_next == EL_ITEM_END || te_next == EL_SEQ_END)
                  phase_next = PH_LEN32;
                else do_fin = 1'b1;
              end else if (ex) phase_next = PH_VR;
              else phase_next = PH_LEN32;
            end
          end
          PH_VR: begin
            if (fbc == 3'd0) begin
              vr_next = {data_byte, 8'h0}; fbc_next = 3'd1;
            end else begin
              vr_next = {vr[15:8], data_byte}; fbc_next = 3'd0;
              phase_next = long_vr(vr_next) ? PH_RES : PH_LEN16;
            end
          end
          PH_RES: begin
            fbc_next = fbc + 3'd1;
            if (fbc_next >= 3'd2) begin
              fbc_next = 3'd0; phase_next = PH_LEN32;
            end
          end
          PH_LEN16, PH_LEN32: begin
            len_next = len | (32'(data_byte) << {fbc[1:0], 3'b000});
            fbc_next = fbc + 3'd1;
            if (fbc_next >= ((phase == PH_LEN16) ? 3'd2 : 3'd4)) begin
              fbc_next = 3'd0; do_fin = 1'b1;
            end
          end
          PH_VALUE: begin
            if (tg == GRP_META && te == EL_SYNTAX) begin
              for (int k = 0; k < 3; k++)
                if (idx >= 32'd20 || uid_char(2'(k), idx[4:0]) != data_byte)
                  uidm_next[k] = 1'b0;
            end
            if (rem != 32'd0) rem_next = rem - 32'd1;
            last = (rem_next == 32'd0);
            e = mk(KIND_VALUE, tg, te, vr, len, data_byte, last, le, ex);
            qwr.r0 = e; n = 2'd1;
            if (last) do_done = 1'b1;
          end
          default: ;
        endcase
        if (do_fin) begin
          e = mk(KIND_HEADER, tg_next, te_next, vr_next, len_next, 8'h0, 1'b0, le, ex);
          if (n == 2'd0) qwr.r0 = e; else qwr.r1 = e;
          n = n + 2'd1;
          uidm_next = 3'b111;
          if (len_next == 32'h0 || len_next == LEN_UNDEF) do_done = 1'b1;
          else begin
            rem_next = len_next; phase_next = PH_VALUE;
          end
        end
        if (do_done) begin
          if (tg_next == GRP_META && te_next == EL_SYNTAX) begin
            m0 = uidm_next[0] && (len_next == 32'd19 || len_next == 32'd20);
            m1 = uidm_next[1] && (len_next == 32'd19 || len_next == 32'd20);
            m2 = uidm_next[2] && (len_next == 32'd17 || len_next == 32'd18);
            if (m0) begin le_next = 1'b1; ex_next = 1'b1; do_next = 1'b1; end
            else if (m1) begin le_next = 1'b0; ex_next = 1'b1; do_next = 1'b1; end
            else if (m2) begin le_next = 1'b1; ex_next = 1'b0; do_next = 1'b1; end
            else begin
              e = mk(KIND_SYNTAX, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 1'b0, le, ex);
              if (n == 2'd0) qwr.r0 = e; else qwr.r1 = e;
              n = n + 2'd1; halted_next = 1'b1;
            end
          end else do_next = 1'b1;
        end
        if (do_next) begin
          if ({1'b0, slen} > ({1'b0, pos_next} + 33'd6)) begin
            phase_next = PH_TAG; fbc_next = 3'd0; tg_next = 16'h0; te_next = 16'h0;
          end else begin
            e = mk(KIND_END_OK, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 1'b0, le_next, ex_next);
            if (n == 2'd0) qwr.r0 = e; else qwr.r1 = e;
            n = n + 2'd1; halted_next = 1'b1;
          end
        end
        if (!halted_next && pos_next >= slen) begin
          e = mk(KIND_TRUNC, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 1'b0, le_next, ex_next);
          if (n == 2'd0) qwr.r0 = e; else qwr.r1 = e;
          n = n + 2'd1; halted_next = 1'b1;
        end
      end
    end
    qwr.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PRE; pos <= '0; fbc <= '0; tg <= '0; te <= '0; vr <= '0;
      len <= '0; rem <= '0; ex <= 1'b1; le <= 1'b1; uidm <= 3'b111; halted <= 1'b0;
      slen <= '0;
    end else begin
      phase <= phase_next; pos <= pos_next; fbc <= fbc_next; tg <= tg_next;
      te <= te_next; vr <= vr_next; len <= len_next; rem <= rem_next; ex <= ex_next;
      le <= le_next; uidm <= uidm_next; halted <= halted_next;
      if (cfg_we) slen <= cfg_data;
    end
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt cleared without reset");
  a_no_out_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> qwr.count == 2'd0) else $error("record while halted");
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(pos)) else $error("position moved without a byte");
`endif

endmodule

FILE: design/dehp_queue.sv
// Back end: short record queue, two writes and one read per cycle.
`timescale 1ns / 1ps
module dehp_queue
  import dehp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  qwr_t qwr,
  input  logic rd,
  output rec_t head,
  output logic empty,
  output logic full
);

  rec_t mem [QDepth];
  logic [QPtrW:0] wptr, rptr, cnt;
  logic [QPtrW-1:0] w1;

  assign cnt = wptr - rptr;
  assign empty = (cnt == '0);
  assign full = (cnt > (QPtrW+1)'(QDepth - 2));
  assign head = mem[rptr[QPtrW-1:0]];
  assign w1 = wptr[QPtrW-1:0] + QPtrW'(1);

  always_ff @(posedge clk) begin
    if (qwr.count != 2'd0) mem[wptr[QPtrW-1:0]] <= qwr.r0;
    if (qwr.count == 2'd2) mem[w1] <= qwr.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0;
    end else begin
      wptr <= wptr + (QPtrW+1)'(qwr.count);
      if (rd && !empty) rptr <= rptr + (QPtrW+1)'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QPtrW+1)'(QDepth)) else $error("queue overflow");
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("queue not empty after reset");
  a_pop_drops: assert property (@(posedge clk) disable iff (rst)
    (rd && !empty && qwr.count == 2'd0) |=> cnt == $past(cnt) - 1'b1)
    else $error("pop lost");
`endif

endmodule

FILE: design/dicom_element_header_parser_top.sv
// Top level of the DICOM element header parser.
//
// Usage: the file stream enters one byte per request on data_byte; a byte is
// taken at a clock edge where push is high and full is low. Results come out
// like a queue: while empty is low the oldest record is on the result ports,
// and pop with empty low takes it. Kinds: header, value byte, end ok, not
// DICM, unsupported syntax, truncated. A fault or end halts the parser until
// reset; further bytes are taken and dropped.
// stream_length is written on cfg_valid/cfg_data; cfg_ready is always high.
// A record enters the queue at the clock edge that takes the byte causing it.
// Throughput: one byte per cycle while full is low; a byte may yield two
// records, and the four-entry record queue raises full when fewer than two
// slots are free, so a stalled receiver backs up into push.
// Reset (rst, synchronous) empties the queue, clears stream_length and puts
// the parser back to the preamble skip.
`timescale 1ns / 1ps
module dicom_element_header_parser_top
  import dehp_pkg::*;
#(
  parameter int PREAMBLE_BYTES = PreambleBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [15:0] group_id,
  output logic [15:0] element_id,
  output logic [15:0] vr_code,
  output logic [31:0] value_length,
  output logic [7:0]  value_byte,
  output logic        last_of_element,
  output logic        little_endian,
  output logic        explicit_vr
);

  qwr_t qwr;
  rec_t head;

  assign cfg_ready = 1'b1;

  dehp_parser #(.PREAMBLE_BYTES(PREAMBLE_BYTES)) u_parser (
    .clk(clk), .rst(rst), .cfg_we(cfg_valid), .cfg_data(cfg_data),
    .take(push && !full), .data_byte(data_byte), .qwr(qwr)
  );

  dehp_queue u_queue (
    .clk(clk), .rst(rst), .qwr(qwr), .rd(pop), .head(head), .empty(empty), .full(full)
  );

  assign kind = head.kind;
  assign group_id = head.group_id;
  assign element_id = head.element_id;
  assign vr_code = head.vr_code;
  assign value_length = head.value_length;
  assign value_byte = head.value_byte;
  assign last_of_element = head.last_of_element;
  assign little_endian = head.little_endian;
  assign explicit_vr = head.explicit_vr;

endmodule
